/* hw/rtl/rgb_led_matrix_scan_driver_macros.svh */
// Assertion macros shared by the scan driver RTL.
`ifndef RGB_LED_MATRIX_SCAN_DRIVER_MACROS_SVH
`define RGB_LED_MATRIX_SCAN_DRIVER_MACROS_SVH

// Same-cycle implication, checked once reset is released.
`define RLMSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked once reset is released.
`define RLMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rlmsd_pkg.sv */
// Shared types and constants for the RGB LED matrix scan driver.
package rlmsd_pkg;

  localparam int PANEL_ROWS_DEF    = 16;
  localparam int PANEL_COLUMNS_DEF = 32;
  localparam int PLANE_COUNT       = 3;
  localparam int ADDR_W            = 3;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_FILL  = 2'd3
  } cmd_t;

  // Panel pin levels; colour bit 0 red, 1 green, 2 blue.
  typedef struct packed {
    logic              shift_clock;
    logic              latch_level;
    logic [ADDR_W-1:0] row_address;
    logic [2:0]        upper;
    logic [2:0]        lower;
  } pins_t;

  // Update request to the frame store.
  typedef struct packed {
    logic       wr_en;
    logic       clear;
    logic       fill;
    logic [1:0] plane;
    logic [3:0] row;
    logic [4:0] column;
    logic       value;
  } store_ctl_t;

endpackage

/* hw/rtl/rlmsd_frame_store.sv */
// Frame store: one word per scan row pair holding both halves, all planes, all columns.
module rlmsd_frame_store #(
  parameter int PANEL_ROWS    = rlmsd_pkg::PANEL_ROWS_DEF,
  parameter int PANEL_COLUMNS = rlmsd_pkg::PANEL_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rlmsd_pkg::store_ctl_t  ctl,
  input  logic [(PANEL_ROWS/2 > 1 ? $clog2(PANEL_ROWS/2) : 1)-1:0] rd_row,
  output logic [1:0][rlmsd_pkg::PLANE_COUNT-1:0][PANEL_COLUMNS-1:0] rd_word
);

  localparam int HALF   = PANEL_ROWS / 2;
  localparam int ROW_W  = HALF > 1 ? $clog2(HALF) : 1;
  localparam int COL_W  = PANEL_COLUMNS > 1 ? $clog2(PANEL_COLUMNS) : 1;

  // [half][plane][column], half 0 is the upper panel half
  logic [1:0][rlmsd_pkg::PLANE_COUNT-1:0][PANEL_COLUMNS-1:0] store_r [HALF];

  logic             plane_ok;
  logic             pix_ok;
  logic             lower_half;
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;

  always_comb begin
    plane_ok   = 32'(ctl.plane) < rlmsd_pkg::PLANE_COUNT;
    pix_ok     = plane_ok && (32'(ctl.row) < PANEL_ROWS) && (32'(ctl.column) < PANEL_COLUMNS);
    lower_half = 32'(ctl.row) >= HALF;
    wr_row     = ROW_W'(lower_half ? 32'(ctl.row) - HALF : 32'(ctl.row));
    wr_col     = COL_W'(ctl.column);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int h = 0; h < HALF; h++) begin
        store_r[h] <= '0;
      end
    end else if (ctl.fill && plane_ok) begin
      for (int h = 0; h < HALF; h++) begin
        store_r[h][0][ctl.plane] <= '1;
        store_r[h][1][ctl.plane] <= '1;
      end
    end else if (ctl.wr_en && pix_ok) begin
      store_r[wr_row][lower_half][ctl.plane][wr_col] <= ctl.value;
    end
  end

  assign rd_word = store_r[rd_row];

endmodule

/* hw/rtl/rlmsd_scan_seq.sv */
// Scan sequencer: row and phase counters and the held panel pin levels.
module rlmsd_scan_seq #(
  parameter int PANEL_ROWS    = rlmsd_pkg::PANEL_ROWS_DEF,
  parameter int PANEL_COLUMNS = rlmsd_pkg::PANEL_COLUMNS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic tick,
  input  logic [1:0][rlmsd_pkg::PLANE_COUNT-1:0][PANEL_COLUMNS-1:0] row_word,
  output logic [(PANEL_ROWS/2 > 1 ? $clog2(PANEL_ROWS/2) : 1)-1:0] scan_row,
  output rlmsd_pkg::pins_t pins_nxt
);

  localparam int HALF    = PANEL_ROWS / 2;
  localparam int ROW_W   = HALF > 1 ? $clog2(HALF) : 1;
  localparam int COL_W   = PANEL_COLUMNS > 1 ? $clog2(PANEL_COLUMNS) : 1;
  localparam int LATCH   = 2 * PANEL_COLUMNS;
  localparam int PHASE_W = $clog2(LATCH + 1);

  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  rlmsd_pkg::pins_t   pins_r;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   addr;

  always_comb begin
    col       = COL_W'(phase_r >> 1);
    addr      = (row_r == '0) ? ROW_W'(HALF - 1) : row_r - ROW_W'(1);
    row_nxt   = row_r;
    phase_nxt = phase_r;
    pins_nxt  = pins_r;
    if (tick) begin
      pins_nxt.row_address = rlmsd_pkg::ADDR_W'(addr);
      if (32'(phase_r) < LATCH) begin
        pins_nxt.shift_clock = phase_r[0];
        pins_nxt.latch_level = 1'b0;
        for (int p = 0; p < rlmsd_pkg::PLANE_COUNT; p++) begin
          pins_nxt.upper[p] = row_word[0][p][col];
          pins_nxt.lower[p] = row_word[1][p][col];
        end
        phase_nxt = phase_r + PHASE_W'(1);
      end else begin
        // latch phase: blank data, clock held high, move to next row
        pins_nxt.shift_clock = 1'b1;
        pins_nxt.latch_level = 1'b1;
        pins_nxt.upper       = '0;
        pins_nxt.lower       = '0;
        phase_nxt            = '0;
        row_nxt              = (32'(row_r) == HALF - 1) ? '0 : row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      phase_r <= '0;
      pins_r  <= '0;
    end else begin
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
      pins_r  <= pins_nxt;
    end
  end

  assign scan_row = row_r;

endmodule

/* hw/rtl/rgb_led_matrix_scan_driver.sv */
// Top level of the RGB LED matrix scan driver: input and result registers around the core.
// Input reg, then result reg; out_valid rises at the edge after the input reg advances.
// Throughput: one command per cycle while out_ready is high; with both registers full,
// in_ready follows out_ready.
// Reset: store cleared (no clearing pass), scan at row 0 phase 0; output pins not reset.
`include "rgb_led_matrix_scan_driver_macros.svh"

module rgb_led_matrix_scan_driver #(
  parameter int PANEL_ROWS    = rlmsd_pkg::PANEL_ROWS_DEF,
  parameter int PANEL_COLUMNS = rlmsd_pkg::PANEL_COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_pixel_row,
  input  logic [4:0] in_pixel_column,
  input  logic [1:0] in_colour_plane,
  input  logic       in_bit_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_shift_clock,
  output logic       out_latch_level,
  output logic [2:0] out_row_address,
  output logic       out_upper_red,
  output logic       out_upper_green,
  output logic       out_upper_blue,
  output logic       out_lower_red,
  output logic       out_lower_green,
  output logic       out_lower_blue
);

  localparam int ROW_W = PANEL_ROWS / 2 > 1 ? $clog2(PANEL_ROWS / 2) : 1;

  logic              s1_valid_r, s1_valid_nxt;
  rlmsd_pkg::cmd_t   s1_cmd_r;
  logic [3:0]        s1_row_r;
  logic [4:0]        s1_col_r;
  logic [1:0]        s1_plane_r;
  logic              s1_value_r;
  logic              out_valid_r, out_valid_nxt;
  rlmsd_pkg::pins_t  out_pins_r;
  logic              advance;
  logic              in_xfer;
  logic              s1_stalled;
  logic              latch_blank;

  rlmsd_pkg::store_ctl_t ctl;
  logic [1:0][rlmsd_pkg::PLANE_COUNT-1:0][PANEL_COLUMNS-1:0] row_word;
  logic [ROW_W-1:0]  scan_row;
  rlmsd_pkg::pins_t  pins_nxt;

  always_comb begin
    advance       = s1_valid_r && (!out_valid_r || out_ready);
    in_ready      = !s1_valid_r || advance;
    in_xfer       = in_valid && in_ready;
    s1_valid_nxt  = in_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    s1_stalled    = s1_valid_r && out_valid_r && !out_ready;
    latch_blank   = out_pins_r.shift_clock && (out_pins_r.upper == 3'b000) &&
                    (out_pins_r.lower == 3'b000);

    ctl.wr_en  = advance && (s1_cmd_r == rlmsd_pkg::CMD_WRITE);
    ctl.clear  = advance && (s1_cmd_r == rlmsd_pkg::CMD_CLEAR);
    ctl.fill   = advance && (s1_cmd_r == rlmsd_pkg::CMD_FILL);
    ctl.plane  = s1_plane_r;
    ctl.row    = s1_row_r;
    ctl.column = s1_col_r;
    ctl.value  = s1_value_r;
  end

  rlmsd_frame_store #(
    .PANEL_ROWS    (PANEL_ROWS),
    .PANEL_COLUMNS (PANEL_COLUMNS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_row  (scan_row),
    .rd_word (row_word)
  );

  rlmsd_scan_seq #(
    .PANEL_ROWS    (PANEL_ROWS),
    .PANEL_COLUMNS (PANEL_COLUMNS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (advance && (s1_cmd_r == rlmsd_pkg::CMD_TICK)),
    .row_word (row_word),
    .scan_row (scan_row),
    .pins_nxt (pins_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r   <= rlmsd_pkg::cmd_t'(in_cmd);
      s1_row_r   <= in_pixel_row;
      s1_col_r   <= in_pixel_column;
      s1_plane_r <= in_colour_plane;
      s1_value_r <= in_bit_value;
    end
    if (advance) begin
      out_pins_r <= pins_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_shift_clock = out_pins_r.shift_clock;
  assign out_latch_level = out_pins_r.latch_level;
  assign out_row_address = out_pins_r.row_address;
  assign out_upper_red   = out_pins_r.upper[0];
  assign out_upper_green = out_pins_r.upper[1];
  assign out_upper_blue  = out_pins_r.upper[2];
  assign out_lower_red   = out_pins_r.lower[0];
  assign out_lower_green = out_pins_r.lower[1];
  assign out_lower_blue  = out_pins_r.lower[2];

  `RLMSD_ASSERT_NEXT(a_stall_holds_s1, s1_stalled, s1_valid_r && out_valid_r, "stalled command lost")
  `RLMSD_ASSERT_NEXT(a_xfer_loads_s1, in_xfer, s1_valid_r, "transfer not held in input register")
  `RLMSD_ASSERT_IMPL(a_latch_blanks, out_valid_r && out_latch_level, latch_blank, "latch not blanked")

endmodule

/* sim/rgb_led_matrix_scan_driver_test.sv */
// Self-checking testbench for the RGB LED matrix scan driver: command stream, pin prediction.
module rgb_led_matrix_scan_driver_test;

  localparam int ROWS        = rlmsd_pkg::PANEL_ROWS_DEF;
  localparam int COLS        = rlmsd_pkg::PANEL_COLUMNS_DEF;
  localparam int HALF        = ROWS / 2;
  localparam int LATCH_PHASE = 2 * COLS;
  localparam int RANDOM_CMDS = 2000;

  localparam logic [1:0] PLANE_RED    = 2'd0;
  localparam logic [1:0] PLANE_GREEN  = 2'd1;
  localparam logic [1:0] PLANE_BLUE   = 2'd2;
  localparam logic [1:0] PLANE_UNUSED = 2'd3;

  typedef struct {
    rlmsd_pkg::cmd_t cmd;
    logic [3:0]      row;
    logic [4:0]      column;
    logic [1:0]      plane;
    logic            value;
    int unsigned     gap;
    bit              drain;
  } panel_cmd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_cmd = rlmsd_pkg::CMD_TICK;
  logic [3:0] in_pixel_row = '0;
  logic [4:0] in_pixel_column = '0;
  logic [1:0] in_colour_plane = PLANE_RED;
  logic       in_bit_value = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_shift_clock;
  logic       out_latch_level;
  logic [2:0] out_row_address;
  logic       out_upper_red;
  logic       out_upper_green;
  logic       out_upper_blue;
  logic       out_lower_red;
  logic       out_lower_green;
  logic       out_lower_blue;

  rgb_led_matrix_scan_driver i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_pixel_row    (in_pixel_row),
    .in_pixel_column (in_pixel_column),
    .in_colour_plane (in_colour_plane),
    .in_bit_value    (in_bit_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_shift_clock (out_shift_clock),
    .out_latch_level (out_latch_level),
    .out_row_address (out_row_address),
    .out_upper_red   (out_upper_red),
    .out_upper_green (out_upper_green),
    .out_upper_blue  (out_upper_blue),
    .out_lower_red   (out_lower_red),
    .out_lower_green (out_lower_green),
    .out_lower_blue  (out_lower_blue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted panel state
  logic [2:0] pixel_store [0:ROWS*COLS-1];
  logic [2:0] scan_row_now;
  int unsigned scan_phase_now;
  rlmsd_pkg::pins_t pin_now;

  panel_cmd_t       pending_cmds[$];
  rlmsd_pkg::pins_t pins_expected[$];
  panel_cmd_t       shown_cmd;
  rlmsd_pkg::pins_t want_pins;
  int unsigned hold_left;
  bit          front_armed;
  bit          quiet_sender;
  int unsigned stall_left;
  int unsigned cmds_total;
  int unsigned cmds_sent;
  int unsigned results_checked;
  int unsigned error_count;

  // Applies one command to the predicted state; returns the pin levels after it.
  function automatic rlmsd_pkg::pins_t apply_cmd(panel_cmd_t c);
    int unsigned column;
    int unsigned i;
    case (c.cmd)
      rlmsd_pkg::CMD_TICK: begin
        pin_now.row_address = scan_row_now - 3'd1;
        if (scan_phase_now < LATCH_PHASE) begin
          column = scan_phase_now >> 1;
          pin_now.shift_clock = scan_phase_now[0];
          pin_now.latch_level = 1'b0;
          pin_now.upper = pixel_store[scan_row_now * COLS + column];
          pin_now.lower = pixel_store[(scan_row_now + HALF) * COLS + column];
          scan_phase_now++;
        end else begin
          pin_now.shift_clock = 1'b1;
          pin_now.latch_level = 1'b1;
          pin_now.upper = '0;
          pin_now.lower = '0;
          scan_phase_now = 0;
          scan_row_now = 3'((scan_row_now + 1) % HALF);
        end
      end
      rlmsd_pkg::CMD_WRITE: begin
        if (c.plane < rlmsd_pkg::PLANE_COUNT && c.row < ROWS && c.column < COLS)
          pixel_store[c.row * COLS + c.column][c.plane] = c.value;
      end
      rlmsd_pkg::CMD_CLEAR: begin
        for (i = 0; i < ROWS * COLS; i++) pixel_store[i] = '0;
      end
      default: begin
        if (c.plane < rlmsd_pkg::PLANE_COUNT)
          for (i = 0; i < ROWS * COLS; i++) pixel_store[i][c.plane] = 1'b1;
      end
    endcase
    return pin_now;
  endfunction

  task automatic queue_cmd(rlmsd_pkg::cmd_t cmd, int row, int column, logic [1:0] plane,
                           logic value, bit drain = 1'b0);
    panel_cmd_t c;
    c.cmd    = cmd;
    c.row    = 4'(row);
    c.column = 5'(column);
    c.plane  = plane;
    c.value  = value;
    c.gap    = quiet_sender ? 0 : $urandom_range(0, 6);
    c.drain  = drain;
    pending_cmds.push_back(c);
  endtask

  task automatic flag_mismatch(string what);
    $display("MISMATCH: %s", what);
    error_count++;
  endtask

  // Command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pins_expected.push_back(apply_cmd(shown_cmd));
        cmds_sent++;
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_cmds.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          if (!front_armed) begin
            hold_left = pending_cmds[0].gap;
            front_armed = 1'b1;
          end
          // a draining command waits until the pipeline has emptied
          if (hold_left != 0 || (pending_cmds[0].drain && pins_expected.size() != 0)) begin
            if (hold_left != 0) hold_left--;
            in_valid <= 1'b0;
          end else begin
            shown_cmd = pending_cmds.pop_front();
            front_armed = 1'b0;
            in_valid <= 1'b1;
            in_cmd <= shown_cmd.cmd;
            in_pixel_row <= shown_cmd.row;
            in_pixel_column <= shown_cmd.column;
            in_colour_plane <= shown_cmd.plane;
            in_bit_value <= shown_cmd.value;
          end
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pins_expected.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected", results_checked));
        end else begin
          want_pins = pins_expected.pop_front();
          if (out_shift_clock !== want_pins.shift_clock)
            flag_mismatch($sformatf("result %0d shift_clock %b, expected %b", results_checked,
                                    out_shift_clock, want_pins.shift_clock));
          if (out_latch_level !== want_pins.latch_level)
            flag_mismatch($sformatf("result %0d latch_level %b, expected %b", results_checked,
                                    out_latch_level, want_pins.latch_level));
          if (out_row_address !== want_pins.row_address)
            flag_mismatch($sformatf("result %0d row_address %0d, expected %0d", results_checked,
                                    out_row_address, want_pins.row_address));
          if (out_upper_red !== want_pins.upper[0])
            flag_mismatch($sformatf("result %0d upper_red %b, expected %b", results_checked,
                                    out_upper_red, want_pins.upper[0]));
          if (out_upper_green !== want_pins.upper[1])
            flag_mismatch($sformatf("result %0d upper_green %b, expected %b", results_checked,
                                    out_upper_green, want_pins.upper[1]));
          if (out_upper_blue !== want_pins.upper[2])
            flag_mismatch($sformatf("result %0d upper_blue %b, expected %b", results_checked,
                                    out_upper_blue, want_pins.upper[2]));
          if (out_lower_red !== want_pins.lower[0])
            flag_mismatch($sformatf("result %0d lower_red %b, expected %b", results_checked,
                                    out_lower_red, want_pins.lower[0]));
          if (out_lower_green !== want_pins.lower[1])
            flag_mismatch($sformatf("result %0d lower_green %b, expected %b", results_checked,
                                    out_lower_green, want_pins.lower[1]));
          if (out_lower_blue !== want_pins.lower[2])
            flag_mismatch($sformatf("result %0d lower_blue %b, expected %b", results_checked,
                                    out_lower_blue, want_pins.lower[2]));
        end
        results_checked++;
        // every fourth block of results runs with no back-pressure
        stall_left = ((results_checked / 256) % 4 == 1) ? 0 : $urandom_range(0, 6);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned pick;
    logic [1:0]  plane;

    for (i = 0; i < ROWS * COLS; i++) pixel_store[i] = '0;
    scan_row_now = '0;
    scan_phase_now = 0;
    pin_now = '0;

    // Directed: store corners, both halves, unused plane, fill and clear, scan start.
    queue_cmd(rlmsd_pkg::CMD_TICK, 0, 0, PLANE_RED, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_WRITE, 0, 0, PLANE_RED, 1'b1);
    queue_cmd(rlmsd_pkg::CMD_WRITE, 8, 0, PLANE_GREEN, 1'b1);
    queue_cmd(rlmsd_pkg::CMD_WRITE, ROWS - 1, COLS - 1, PLANE_BLUE, 1'b1);
    queue_cmd(rlmsd_pkg::CMD_WRITE, 0, 0, PLANE_UNUSED, 1'b1);
    queue_cmd(rlmsd_pkg::CMD_WRITE, 0, 1, PLANE_UNUSED, 1'b1);
    queue_cmd(rlmsd_pkg::CMD_FILL, 15, 31, PLANE_UNUSED, 1'b1);
    queue_cmd(rlmsd_pkg::CMD_TICK, 15, 31, PLANE_BLUE, 1'b1);
    queue_cmd(rlmsd_pkg::CMD_TICK, 0, 0, PLANE_RED, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_TICK, 0, 0, PLANE_RED, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_WRITE, 0, 0, PLANE_RED, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_WRITE, 8, 1, PLANE_RED, 1'b1);
    queue_cmd(rlmsd_pkg::CMD_TICK, 0, 0, PLANE_RED, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_TICK, 0, 0, PLANE_RED, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_FILL, 0, 0, PLANE_GREEN, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_TICK, 0, 0, PLANE_RED, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_CLEAR, 7, 16, PLANE_BLUE, 1'b1);
    queue_cmd(rlmsd_pkg::CMD_TICK, 0, 0, PLANE_RED, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_FILL, 0, 0, PLANE_BLUE, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_FILL, 0, 0, PLANE_RED, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_TICK, 0, 0, PLANE_RED, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_CLEAR, 0, 0, PLANE_RED, 1'b0);
    queue_cmd(rlmsd_pkg::CMD_TICK, 0, 0, PLANE_RED, 1'b0, 1'b1);

    // Random: mostly ticks so the scan runs through whole frames, with writes, fills and clears mixed in.
    for (i = 0; i < RANDOM_CMDS; i++) begin
      quiet_sender = ((i / 256) % 4 == 2);
      plane = ($urandom_range(0, 15) == 0) ? PLANE_UNUSED : 2'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      if (pick < 60)
        queue_cmd(rlmsd_pkg::CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 31), plane,
                  1'($urandom), i == RANDOM_CMDS / 2);
      else if (pick < 90)
        queue_cmd(rlmsd_pkg::CMD_WRITE, $urandom_range(0, 15), $urandom_range(0, 31), plane,
                  1'($urandom));
      else if (pick < 96)
        queue_cmd(rlmsd_pkg::CMD_FILL, $urandom_range(0, 15), $urandom_range(0, 31), plane,
                  1'($urandom));
      else
        queue_cmd(rlmsd_pkg::CMD_CLEAR, $urandom_range(0, 15), $urandom_range(0, 31), plane,
                  1'($urandom));
    end
    cmds_total = pending_cmds.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (cmds_sent != cmds_total || pins_expected.size() != 0) @(posedge clk);
    // input and result registers: allow time for any stray result
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
